### hw/rtl/tllbp_pkg.sv
// Shared types and constants for the two-level local branch predictor.
package tllbp_pkg;

  // Two-bit saturating counter codes
  localparam logic [1:0] CTR_STRONG_NT = 2'b00;
  localparam logic [1:0] CTR_WEAK_NT   = 2'b01;
  localparam logic [1:0] CTR_WEAK_T    = 2'b10;
  localparam logic [1:0] CTR_STRONG_T  = 2'b11;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR
  } state_e;

  // Per-cycle command to a table
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } mem_cmd_t;

  function automatic logic [1:0] ctr_next(logic [1:0] ctr, logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_STRONG_T) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_STRONG_NT) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

### hw/rtl/tllbp_if.sv
// Handshake interfaces for resolved branches and predictions.
interface tllbp_br_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_pc;
  logic        actual_taken;

  modport source (output valid, output branch_pc, output actual_taken, input ready);
  modport sink   (input valid, input branch_pc, input actual_taken, output ready);
endinterface

interface tllbp_pred_if;
  logic valid;
  logic ready;
  logic predicted_taken;

  modport source (output valid, output predicted_taken, input ready);
  modport sink   (input valid, input predicted_taken, output ready);
endinterface

### hw/rtl/tllbp_hist.sv
// Local history table: per-branch shift registers and pattern index build.
module tllbp_hist
  import tllbp_pkg::*;
#(
  parameter int unsigned PATTERN_INDEX_BITS = 12,
  parameter int unsigned HISTORY_TABLE_BITS = 10,
  parameter int unsigned HISTORY_BITS       = 4
) (
  input  logic                          clk_i,
  input  mem_cmd_t                      cmd_i,
  input  logic [HISTORY_TABLE_BITS-1:0] clr_addr_i,
  input  logic [31:0]                   rd_pc_i,
  input  logic [31:0]                   pc_i,
  input  logic                          taken_i,
  output logic [PATTERN_INDEX_BITS-1:0] pidx_o
);

  localparam int unsigned Depth = 1 << HISTORY_TABLE_BITS;

  logic [HISTORY_BITS-1:0]    mem_q [Depth];
  logic [HISTORY_BITS-1:0]    rdata_q;
  logic [HISTORY_BITS:0]      shifted;
  logic [29+HISTORY_BITS:0]   idx_cat;
  logic [HISTORY_TABLE_BITS-1:0] rd_addr;
  logic [HISTORY_TABLE_BITS-1:0] wr_addr;

  assign rd_addr = rd_pc_i[HISTORY_TABLE_BITS+1:2];
  assign wr_addr = pc_i[HISTORY_TABLE_BITS+1:2];
  assign shifted = {rdata_q, taken_i};
  // PC word above the history, kept to the pattern index width
  assign idx_cat = {pc_i[31:2], rdata_q};
  assign pidx_o  = idx_cat[PATTERN_INDEX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_addr_i] <= '0;
    end else if (cmd_i.wr) begin
      mem_q[wr_addr] <= shifted[HISTORY_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

### hw/rtl/tllbp_ctr.sv
// Pattern history table of two-bit saturating counters.
module tllbp_ctr
  import tllbp_pkg::*;
#(
  parameter int unsigned PATTERN_INDEX_BITS = 12
) (
  input  logic                          clk_i,
  input  mem_cmd_t                      cmd_i,
  input  logic [PATTERN_INDEX_BITS-1:0] clr_addr_i,
  input  logic [PATTERN_INDEX_BITS-1:0] rd_idx_i,
  input  logic                          taken_i,
  output logic                          pred_o
);

  localparam int unsigned Depth = 1 << PATTERN_INDEX_BITS;

  logic [1:0]                    mem_q [Depth];
  logic [1:0]                    rdata_q;
  logic [PATTERN_INDEX_BITS-1:0] idx_q;

  assign pred_o = rdata_q[1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_addr_i] <= CTR_WEAK_T;
    end else if (cmd_i.wr) begin
      mem_q[idx_q] <= ctr_next(rdata_q, taken_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_idx_i];
      idx_q   <= rd_idx_i;
    end
  end

endmodule

### hw/rtl/two_level_local_branch_predictor.sv
// Top level of the two-level local history branch predictor.
//
//   channel  | dir | modport | payload
//   br_i     | in  | sink    | branch_pc[31:0], actual_taken
//   pred_o   | out | source  | predicted_taken
//
// Each branch goes through history read, counter read with history write-back, and
// counter write-back into the output register. Both tables are single-port
// synchronous memories and one branch is in flight at a time.
// After reset a clearing pass over all 2^max(PATTERN_INDEX_BITS, HISTORY_TABLE_BITS)
// addresses (4096 by default) runs before the first transaction is taken.
// A stalled output holds the finished branch in the counter stage; one result
// may wait in the output register while the next branch is taken.
module two_level_local_branch_predictor
  import tllbp_pkg::*;
#(
  parameter int unsigned PATTERN_INDEX_BITS = 12,
  parameter int unsigned HISTORY_TABLE_BITS = 10,
  parameter int unsigned HISTORY_BITS       = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tllbp_br_if.sink            br_i,
  tllbp_pred_if.source        pred_o
);

  localparam int unsigned ClrBits = (PATTERN_INDEX_BITS > HISTORY_TABLE_BITS) ?
                                    PATTERN_INDEX_BITS : HISTORY_TABLE_BITS;

  state_e               state_q, state_d;
  logic [ClrBits-1:0]   clr_q, clr_d;
  logic [31:0]          pc_q, pc_d;
  logic                 taken_q, taken_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_pred_q, out_pred_d;
  mem_cmd_t             hist_cmd, ctr_cmd;
  logic [PATTERN_INDEX_BITS-1:0] pidx;
  logic                 ctr_pred;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q       <= pc_d;
    taken_q    <= taken_d;
    out_pred_q <= out_pred_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pc_d        = pc_q;
    taken_d     = taken_q;
    out_pred_d  = out_pred_q;
    out_valid_d = out_valid_q && !pred_o.ready;
    hist_cmd    = '0;
    ctr_cmd     = '0;
    br_i.ready  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        hist_cmd.clr = 1'b1;
        ctr_cmd.clr  = 1'b1;
        clr_d        = clr_q + ClrBits'(1);
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        br_i.ready = 1'b1;
        if (br_i.valid) begin
          pc_d        = br_i.branch_pc;
          taken_d     = br_i.actual_taken;
          hist_cmd.rd = 1'b1;
          state_d     = ST_HIST;
        end
      end
      ST_HIST: begin
        hist_cmd.wr = 1'b1;
        ctr_cmd.rd  = 1'b1;
        state_d     = ST_CTR;
      end
      ST_CTR: begin
        // wait for the output register to drain
        if (!out_valid_q || pred_o.ready) begin
          ctr_cmd.wr  = 1'b1;
          out_valid_d = 1'b1;
          out_pred_d  = ctr_pred;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign pred_o.valid           = out_valid_q;
  assign pred_o.predicted_taken = out_pred_q;

  tllbp_hist #(
    .PATTERN_INDEX_BITS (PATTERN_INDEX_BITS),
    .HISTORY_TABLE_BITS (HISTORY_TABLE_BITS),
    .HISTORY_BITS       (HISTORY_BITS)
  ) u_hist (
    .clk_i      (clk_i),
    .cmd_i      (hist_cmd),
    .clr_addr_i (clr_q[HISTORY_TABLE_BITS-1:0]),
    .rd_pc_i    (br_i.branch_pc),
    .pc_i       (pc_q),
    .taken_i    (taken_q),
    .pidx_o     (pidx)
  );

  tllbp_ctr #(
    .PATTERN_INDEX_BITS (PATTERN_INDEX_BITS)
  ) u_ctr (
    .clk_i      (clk_i),
    .cmd_i      (ctr_cmd),
    .clr_addr_i (clr_q[PATTERN_INDEX_BITS-1:0]),
    .rd_idx_i   (pidx),
    .taken_i    (taken_q),
    .pred_o     (ctr_pred)
  );

endmodule
